// ----- hw/rtl/dkh_pkg.sv -----
// ----------------------------------------------------------------------------
// dkh_pkg
// Shared constants and types for the two-bit DNA k-mer modular hash.
// ----------------------------------------------------------------------------
package dkh_pkg;

  localparam int CHAR_W           = 8;
  localparam int SIZE_W           = 50;
  localparam int ACC_W            = 64;
  localparam int FIRST_PART_CHARS = 32;
  localparam int POS_W            = $clog2(FIRST_PART_CHARS + 1);
  localparam int CNT_W            = $clog2(ACC_W + 1);

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1114523);
  localparam logic [ACC_W-1:0]  SUM_RESET  = ACC_W'(1);

  // finished string handed from the accumulator to the back stage
  typedef struct packed {
    logic             valid;
    logic [ACC_W-1:0] first;
    logic [ACC_W-1:0] second;
  } job_t;

  // request to the serial remainder unit
  typedef struct packed {
    logic              start;
    logic [ACC_W-1:0]  dividend;
    logic [SIZE_W-1:0] divisor;
  } mod_req_t;

  // result of the serial remainder unit
  typedef struct packed {
    logic              done;
    logic [SIZE_W-1:0] rem;
  } mod_rsp_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MODA = 6'b000010,
    S_MODB = 6'b000100,
    S_MUL  = 6'b001000,
    S_MODP = 6'b010000,
    S_DONE = 6'b100000
  } fin_state_t;

endpackage

// ----- hw/rtl/dkh_accum.sv -----
// ----------------------------------------------------------------------------
// dkh_accum
// Shifts two-bit character codes into the two 64-bit accumulators.
// ----------------------------------------------------------------------------
module dkh_accum import dkh_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CHAR_W-1:0] character,
  input  logic              last_char,
  input  logic              fin_ready,
  output job_t              job
);

  logic [ACC_W-1:0] first_sum;
  logic [ACC_W-1:0] second_sum;
  logic [ACC_W-1:0] first_next;
  logic [ACC_W-1:0] second_next;
  logic [POS_W-1:0] char_position;
  logic [1:0]       code;
  logic             in_first;
  logic             accept;

  // only a closing character has to wait for the back stage
  assign in_stall = last_char && !fin_ready;
  assign accept   = in_valid && !in_stall;
  assign code     = character[2:1];
  assign in_first = char_position < POS_W'(FIRST_PART_CHARS);

  always_comb begin
    first_next  = first_sum;
    second_next = second_sum;
    if (in_first) begin
      first_next = {first_sum[ACC_W-3:0], code};
    end else begin
      second_next = {second_sum[ACC_W-3:0], code};
    end
  end

  assign job.valid  = accept && last_char;
  assign job.first  = first_next;
  assign job.second = second_next;

  always_ff @(posedge clk) begin
    if (rst || (accept && last_char)) begin
      first_sum     <= SUM_RESET;
      second_sum    <= SUM_RESET;
      char_position <= '0;
    end else if (accept) begin
      first_sum  <= first_next;
      second_sum <= second_next;
      if (in_first) begin
        char_position <= char_position + POS_W'(1);
      end
    end
  end

endmodule

// ----- hw/rtl/dkh_modunit.sv -----
// ----------------------------------------------------------------------------
// dkh_modunit
// Restoring remainder, one dividend bit per cycle, 64 steps per operation.
// ----------------------------------------------------------------------------
module dkh_modunit import dkh_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mod_req_t req,
  output mod_rsp_t rsp
);

  logic [ACC_W-1:0]  dividend;
  logic [SIZE_W-1:0] rem;
  logic [CNT_W-1:0]  cnt;
  logic              done;
  logic [SIZE_W:0]   trial;
  logic [SIZE_W:0]   diff;
  logic [SIZE_W-1:0] rem_next;

  assign trial = {rem, dividend[ACC_W-1]};
  assign diff  = trial - {1'b0, req.divisor};

  // partial remainder stays below the divisor, so the trial fits one bit wider
  always_comb begin
    if (trial >= {1'b0, req.divisor}) begin
      rem_next = diff[SIZE_W-1:0];
    end else begin
      rem_next = trial[SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (req.start) begin
      cnt  <= CNT_W'(ACC_W);
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt  <= cnt - CNT_W'(1);
      done <= (cnt == CNT_W'(1));
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dividend <= req.dividend;
      rem      <= '0;
    end else if (cnt != '0) begin
      dividend <= {dividend[ACC_W-2:0], 1'b0};
      rem      <= rem_next;
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem;

endmodule

// ----- hw/rtl/dkh_finish.sv -----
// ----------------------------------------------------------------------------
// dkh_finish
// Back stage: both remainders, serial 64-bit wrapped product, final
// remainder and the output register.
// ----------------------------------------------------------------------------
module dkh_finish import dkh_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  job_t              job,
  input  logic [SIZE_W-1:0] table_size,
  output logic              fin_ready,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SIZE_W-1:0] bucket_index
);

  fin_state_t        state;
  logic [ACC_W-1:0]  first_q;
  logic [ACC_W-1:0]  second_q;
  logic [SIZE_W-1:0] a_q;
  logic [SIZE_W-1:0] b_q;
  logic [ACC_W-1:0]  mcand;
  logic [ACC_W-1:0]  prod;
  logic [CNT_W-1:0]  mul_cnt;
  logic              mod_start;
  logic              out_free;
  mod_req_t          mreq;
  mod_rsp_t          mrsp;

  assign fin_ready = (state == S_IDLE);
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    mreq.start   = mod_start;
    mreq.divisor = table_size;
    case (state)
      S_MODA:  mreq.dividend = first_q;
      S_MODB:  mreq.dividend = second_q;
      default: mreq.dividend = prod;
    endcase
  end

  dkh_modunit u_mod (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mod_start <= 1'b0;
      mul_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      // one-cycle start pulse for each remainder pass
      mod_start <= ((state == S_IDLE) && job.valid) ||
                   ((state == S_MODA) && mrsp.done) ||
                   ((state == S_MUL) && (mul_cnt == CNT_W'(1)));
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (job.valid) begin
            state <= S_MODA;
          end
        end
        S_MODA: begin
          if (mrsp.done) begin
            state <= S_MODB;
          end
        end
        S_MODB: begin
          if (mrsp.done) begin
            state   <= S_MUL;
            mul_cnt <= CNT_W'(SIZE_W);
          end
        end
        S_MUL: begin
          mul_cnt <= mul_cnt - CNT_W'(1);
          if (mul_cnt == CNT_W'(1)) begin
            state <= S_MODP;
          end
        end
        S_MODP: begin
          if (mrsp.done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (job.valid) begin
          first_q  <= job.first;
          second_q <= job.second;
        end
      end
      S_MODA: begin
        if (mrsp.done) begin
          a_q <= mrsp.rem;
        end
      end
      S_MODB: begin
        if (mrsp.done) begin
          b_q   <= mrsp.rem;
          mcand <= ACC_W'(a_q);
          prod  <= '0;
        end
      end
      S_MUL: begin
        // shift-and-add, multiplier bits lsb first, product wraps at 64 bits
        if (b_q[0]) begin
          prod <= prod + mcand;
        end
        mcand <= {mcand[ACC_W-2:0], 1'b0};
        b_q   <= {1'b0, b_q[SIZE_W-1:1]};
      end
      S_MODP: begin
        if (mrsp.done) begin
          // zero modulus gives index zero
          a_q <= (table_size == '0) ? '0 : mrsp.rem;
        end
      end
      S_DONE: begin
        if (out_free) begin
          bucket_index <= a_q;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- hw/rtl/dna_kmer_modular_hash.sv -----
// ----------------------------------------------------------------------------
// dna_kmer_modular_hash
// Two-bit DNA k-mer hash with a programmable modulus.
// ----------------------------------------------------------------------------
// Characters are taken one per cycle; each adds its two-bit code to the
// accumulators with no added latency. A beat with last_char set closes the
// string and hands it to a back stage that computes the bucket index with
// a bit-serial remainder unit (three passes) and a bit-serial shift-and-add
// multiplier. The next string streams in while the back stage works; only
// its last character is stalled until the back stage is free. The finished
// index waits in an output register, so a stalled output holds up the back
// stage for the following string only once that string's index is ready.
// table_size should be written only while no string is in flight.
module dna_kmer_modular_hash import dkh_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              table_size_wr,
  input  logic [SIZE_W-1:0] table_size_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CHAR_W-1:0] character,
  input  logic              last_char,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SIZE_W-1:0] bucket_index
);

  logic [SIZE_W-1:0] table_size;
  logic              fin_ready;
  job_t              job;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= SIZE_RESET;
    end else if (table_size_wr) begin
      table_size <= table_size_wdata;
    end
  end

  dkh_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .character (character),
    .last_char (last_char),
    .fin_ready (fin_ready),
    .job       (job)
  );

  dkh_finish u_finish (
    .clk          (clk),
    .rst          (rst),
    .job          (job),
    .table_size   (table_size),
    .fin_ready    (fin_ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .bucket_index (bucket_index)
  );

endmodule

// ----- hw/rtl/dkh_checker.sv -----
// ----------------------------------------------------------------------------
// dkh_checker
// Port-level checks for dna_kmer_modular_hash, bound to the top level.
// ----------------------------------------------------------------------------
module dkh_checker import dkh_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              last_char,
  input logic              out_valid,
  input logic              out_stall,
  input logic [SIZE_W-1:0] bucket_index
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(bucket_index))
    else $error("stalled result beat changed");

  // only a closing character is ever held back
  a_stall_last: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |-> last_char)
    else $error("stall on a non-closing character");

  // a closing character occupies the back stage, so two strings never close back to back
  a_no_double_close: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last_char |=> !(in_valid && !in_stall && last_char))
    else $error("two strings closed in consecutive cycles");

  // no result directly out of reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result beat right after reset");

endmodule

bind dna_kmer_modular_hash dkh_checker u_dkh_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .last_char    (last_char),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .bucket_index (bucket_index)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-bit DNA k-mer modular hash.
// ----------------------------------------------------------------------------
// Strings are fed one character per beat from a queue, with random gaps on
// the input and random stall on the output. A local model of the
// accumulators computes the bucket index of each finished string, and every
// output beat is checked against the oldest expected index. The table size
// is rewritten between phases, while the block is idle, across its extremes.
module tb_top;
  import dkh_pkg::*;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              drain;
  } char_item_t;

  logic              clk              = 1'b0;
  logic              rst              = 1'b1;
  logic              table_size_wr    = 1'b0;
  logic [SIZE_W-1:0] table_size_wdata = '0;
  logic              in_valid         = 1'b0;
  logic              in_stall;
  logic [CHAR_W-1:0] character        = '0;
  logic              last_char        = 1'b0;
  logic              out_valid;
  logic              out_stall        = 1'b0;
  logic [SIZE_W-1:0] bucket_index;

  // model state
  logic [SIZE_W-1:0] modulus   = SIZE_RESET;
  logic [ACC_W-1:0]  head_sum  = SUM_RESET;
  logic [ACC_W-1:0]  tail_sum  = SUM_RESET;
  logic [POS_W-1:0]  head_count = '0;

  char_item_t        char_q[$];
  logic [SIZE_W-1:0] bucket_q[$];

  logic        in_taken   = 1'b0;
  logic        in_calm    = 1'b0;
  logic        out_calm   = 1'b0;
  int unsigned in_gap     = 0;
  int unsigned stall_left = 0;

  int unsigned beats_queued   = 0;
  int unsigned beats_taken    = 0;
  int unsigned strings_queued = 0;
  int unsigned long_strings   = 0;
  int unsigned results_seen   = 0;
  int unsigned size_writes    = 0;
  int unsigned errors         = 0;

  dna_kmer_modular_hash DUT (
    .clk              (clk),
    .rst              (rst),
    .table_size_wr    (table_size_wr),
    .table_size_wdata (table_size_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .character        (character),
    .last_char        (last_char),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .bucket_index     (bucket_index)
  );

  always #6 clk = ~clk;

  // fold one accepted character into the model, queue the index on the last
  function automatic void hash_char(input logic [CHAR_W-1:0] ch, input logic fin);
    logic [1:0]        code;
    logic [ACC_W-1:0]  a;
    logic [ACC_W-1:0]  b;
    logic [ACC_W-1:0]  prod;
    logic [SIZE_W-1:0] idx;
    code = ch[2:1];
    if (head_count < FIRST_PART_CHARS) begin
      head_sum   = {head_sum[ACC_W-3:0], code};
      head_count = head_count + 1'b1;
    end else begin
      tail_sum = {tail_sum[ACC_W-3:0], code};
    end
    if (fin) begin
      idx = '0;
      if (modulus != '0) begin
        a    = head_sum % ACC_W'(modulus);
        b    = tail_sum % ACC_W'(modulus);
        prod = a * b;
        idx  = SIZE_W'(prod % ACC_W'(modulus));
      end
      bucket_q = {bucket_q, idx};
      head_sum   = SUM_RESET;
      tail_sum   = SUM_RESET;
      head_count = '0;
    end
  endfunction

  function automatic int unsigned pick_gap(input logic calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CHAR_W-1:0] pick_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 21) return "A";
    if (r < 42) return "C";
    if (r < 63) return "G";
    if (r < 84) return "T";
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 20);
    if (r < 90) return $urandom_range(21, 64);
    return $urandom_range(65, 96);
  endfunction

  function automatic void queue_char(input logic [CHAR_W-1:0] ch, input logic fin,
                                     input logic drain);
    char_item_t it;
    it.ch    = ch;
    it.last  = fin;
    it.drain = drain;
    char_q = {char_q, it};
    beats_queued++;
  endfunction

  function automatic void queue_string(input int unsigned len, input logic drain);
    for (int unsigned k = 0; k < len; k++) begin
      queue_char(pick_char(), k == len - 1, drain && k == 0);
    end
    strings_queued++;
    if (len > 64) long_strings++;
  endfunction

  function automatic void report_miss(input string msg);
    errors++;
    if (errors <= 10) $display("%0t: %s", $time, msg);
  endfunction

  // input beats feed the model, output beats are checked against it
  always @(posedge clk) begin : beat_monitor
    logic [SIZE_W-1:0] want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (bucket_q.size() == 0) begin
        report_miss($sformatf("bucket_index %0d with no result expected", bucket_index));
      end else begin
        want = bucket_q.pop_front();
        if (bucket_index !== want) begin
          report_miss($sformatf("bucket_index mismatch: expected %0d, got %0d",
                                want, bucket_index));
        end
      end
    end
    if (!rst && in_valid && !in_stall) begin
      hash_char(character, last_char);
      beats_taken++;
    end
    in_taken <= !rst && in_valid && !in_stall;
  end

  always @(negedge clk) begin : char_driver
    char_item_t nxt;
    logic       hold;
    logic       go;
    hold = in_valid && !in_taken;
    go   = 1'b0;
    if ($urandom_range(0, 199) == 0) in_calm <= !in_calm;
    if (!rst && !hold) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
      end else if (char_q.size() > 0 && !(char_q[0].drain && bucket_q.size() != 0)) begin
        // a drain beat waits until every pending index has come out
        go = 1'b1;
      end
    end
    if (go) begin
      nxt = char_q.pop_front();
      character <= nxt.ch;
      last_char <= nxt.last;
      in_valid  <= 1'b1;
      in_gap    <= pick_gap(in_calm);
    end else if (!hold) begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin : stall_driver
    if ($urandom_range(0, 199) == 0) out_calm <= !out_calm;
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= !out_calm && ($urandom_range(0, 3) == 0);
      stall_left <= pick_gap(1'b0);
    end
  end

  task automatic wait_idle();
    do @(negedge clk); while (beats_taken != beats_queued || bucket_q.size() != 0);
    // let the back stage settle before touching the register
    repeat (300) @(negedge clk);
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] v);
    table_size_wdata <= v;
    table_size_wr    <= 1'b1;
    @(negedge clk);
    table_size_wr <= 1'b0;
    modulus = v;
    size_writes++;
  endtask

  initial begin : stimulus
    logic [SIZE_W-1:0] size_set [9];
    int unsigned       phase_start;
    size_set[0] = SIZE_RESET;
    size_set[1] = SIZE_W'(1);
    size_set[2] = '1;
    size_set[3] = '0;
    size_set[4] = SIZE_W'(7);
    size_set[5] = SIZE_W'({$urandom, $urandom}) | (SIZE_W'(1) << (SIZE_W - 1));
    size_set[6] = SIZE_W'(64'd4294967311);
    size_set[7] = SIZE_W'($urandom_range(2, 1000));
    size_set[8] = SIZE_RESET;

    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // single-character strings: each base and the code extremes
    queue_char("A", 1'b1, 1'b0);
    queue_char("C", 1'b1, 1'b0);
    queue_char("T", 1'b1, 1'b0);
    queue_char("G", 1'b1, 1'b0);
    queue_char(8'h00, 1'b1, 1'b0);
    queue_char(8'hFF, 1'b1, 1'b0);
    // mixed string with non-DNA codes inside
    queue_char("G", 1'b0, 1'b0);
    queue_char("A", 1'b0, 1'b0);
    queue_char("T", 1'b0, 1'b0);
    queue_char("T", 1'b0, 1'b0);
    queue_char("A", 1'b0, 1'b0);
    queue_char("C", 1'b0, 1'b0);
    queue_char("N", 1'b0, 1'b0);
    queue_char("c", 1'b0, 1'b0);
    queue_char(8'h80, 1'b0, 1'b0);
    queue_char(8'h7F, 1'b0, 1'b0);
    queue_char("T", 1'b1, 1'b0);
    strings_queued += 7;

    for (int p = 0; p < 9; p++) begin
      if (p != 0) begin
        wait_idle();
        write_size(size_set[p]);
      end
      phase_start = beats_queued;
      while (beats_queued - phase_start < 104) begin
        queue_string(pick_len(), (strings_queued % 8) == 4);
      end
    end

    wait_idle();
    if (bucket_q.size() != 0) begin
      $display("%0d expected bucket indexes never came out", bucket_q.size());
      errors += bucket_q.size();
    end
    $display("covered %0d characters in %0d strings (%0d longer than 64), %0d indexes",
             beats_taken, strings_queued, long_strings, results_seen);
    $display("table size written %0d times, including zero, one and all ones",
             size_writes);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #12_000_000;
    $display("timeout: %0d of %0d beats taken, %0d indexes pending",
             beats_taken, beats_queued, bucket_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/dkh_pkg.sv
hw/rtl/dkh_accum.sv
hw/rtl/dkh_modunit.sv
hw/rtl/dkh_finish.sv
hw/rtl/dna_kmer_modular_hash.sv
hw/rtl/dkh_checker.sv
tb/tb_top.sv
